### hdl/approx_magnitude_vector_normalizer_defines.svh
// assertion macros shared by the normalizer rtl
// expects aclk and aresetn in the scope of the module that uses them
`ifndef APPROX_MAGNITUDE_VECTOR_NORMALIZER_DEFINES_SVH
`define APPROX_MAGNITUDE_VECTOR_NORMALIZER_DEFINES_SVH

// checked only while out of reset
`define AMVN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked at every edge, reset included
`define AMVN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### hdl/amvn_pkg.sv
// constants shared by the approximate magnitude normalizer
// no dependencies
`timescale 1ns / 1ps

package amvn_pkg;

    localparam int COMP_WIDTH_DEF = 16;

    // output field widths
    localparam int UNIT_W = 16;
    localparam int MAG_W  = 16;

    // quotient bits of the q1.15 divide, bit 15 only set for a quotient of one
    localparam int QUOT_BITS    = 16;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = QUOT_BITS / DIV_STEPS;
    localparam int FRONT_STAGES = 3;

    // estimate is kept in 1/32 units
    localparam int EST_FRAC_BITS = 5;
    // numerator shift that makes comp * 2^20 start below the divisor
    localparam int REM_PRESHIFT  = 4;

    localparam logic [UNIT_W-1:0] UNIT_POS_MAX = 16'h7FFF;
    localparam logic [MAG_W-1:0]  MAG_MAX      = 16'hFFFF;

endpackage

### hdl/amvn_front.sv
// front end: absolute values, ordering and magnitude estimate, three stages
// depends on amvn_pkg
`timescale 1ns / 1ps

module amvn_front #(
    parameter int COMP_WIDTH = amvn_pkg::COMP_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic [2:0]              adv,
    input  logic [COMP_WIDTH-1:0]   comp_x,
    input  logic [COMP_WIDTH-1:0]   comp_y,
    input  logic [COMP_WIDTH-1:0]   comp_z,
    output logic [COMP_WIDTH-1:0]   abs_x,
    output logic [COMP_WIDTH-1:0]   abs_y,
    output logic [COMP_WIDTH-1:0]   abs_z,
    output logic [2:0]              neg,
    output logic [COMP_WIDTH+4:0]   est32,
    output logic [amvn_pkg::MAG_W-1:0] mag,
    output logic                    zero
);

    localparam int W  = COMP_WIDTH;
    localparam int EW = COMP_WIDTH + 5;
    localparam int MW = (COMP_WIDTH > amvn_pkg::MAG_W) ? COMP_WIDTH : amvn_pkg::MAG_W;

    // stage 0
    logic [W-1:0]  a0_reg [3];
    logic [2:0]    neg0_reg;
    // stage 1
    logic [W-1:0]  a1_reg [3];
    logic [2:0]    neg1_reg;
    logic [W-1:0]  hi_reg, mid_reg, lo_reg;
    // stage 2
    logic [W-1:0]  a2_reg [3];
    logic [2:0]    neg2_reg;
    logic [EW-1:0] est_reg;
    logic [amvn_pkg::MAG_W-1:0] mag_reg;
    logic          zero_reg;

    logic [W-1:0]  hi_next, lo_next, mid_next;
    logic [W+1:0]  sum3;
    logic [EW-1:0] est_next;
    logic [MW-1:0] mag_full;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            neg0_reg  <= {comp_z[W-1], comp_y[W-1], comp_x[W-1]};
            a0_reg[0] <= comp_x[W-1] ? (~comp_x + 1'b1) : comp_x;
            a0_reg[1] <= comp_y[W-1] ? (~comp_y + 1'b1) : comp_y;
            a0_reg[2] <= comp_z[W-1] ? (~comp_z + 1'b1) : comp_z;
        end
    end

    always_comb begin
        hi_next = a0_reg[0];
        if (a0_reg[1] > hi_next) hi_next = a0_reg[1];
        if (a0_reg[2] > hi_next) hi_next = a0_reg[2];
        lo_next = a0_reg[0];
        if (a0_reg[1] < lo_next) lo_next = a0_reg[1];
        if (a0_reg[2] < lo_next) lo_next = a0_reg[2];
        sum3     = (W+2)'(a0_reg[0]) + (W+2)'(a0_reg[1]) + (W+2)'(a0_reg[2]);
        mid_next = W'(sum3 - (W+2)'(hi_next) - (W+2)'(lo_next));
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            a1_reg   <= a0_reg;
            neg1_reg <= neg0_reg;
            hi_reg   <= hi_next;
            mid_reg  <= mid_next;
            lo_reg   <= lo_next;
        end
    end

    // 32*hi + 11*mid + 8*lo
    always_comb begin
        est_next = (EW'(hi_reg) << 5) + (EW'(mid_reg) << 3) + (EW'(mid_reg) << 1)
                 + EW'(mid_reg) + (EW'(lo_reg) << 3);
        mag_full = MW'(est_next >> amvn_pkg::EST_FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            a2_reg   <= a1_reg;
            neg2_reg <= neg1_reg;
            est_reg  <= est_next;
            zero_reg <= (hi_reg == '0);
            mag_reg  <= (mag_full > MW'(amvn_pkg::MAG_MAX)) ? amvn_pkg::MAG_MAX
                                                            : mag_full[amvn_pkg::MAG_W-1:0];
        end
    end

    assign abs_x = a2_reg[0];
    assign abs_y = a2_reg[1];
    assign abs_z = a2_reg[2];
    assign neg   = neg2_reg;
    assign est32 = est_reg;
    assign mag   = mag_reg;
    assign zero  = zero_reg;

endmodule

### hdl/amvn_div_lane.sv
// pipelined restoring divider for one component, a few quotient bits per stage
// depends on amvn_pkg
`timescale 1ns / 1ps

module amvn_div_lane #(
    parameter int COMP_WIDTH = amvn_pkg::COMP_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic [amvn_pkg::DIV_STAGES-1:0]   adv,
    input  logic [COMP_WIDTH-1:0]             abs_in,
    input  logic                              neg_in,
    input  logic [COMP_WIDTH+4:0]             divisor,
    output logic [amvn_pkg::QUOT_BITS-1:0]    quot,
    output logic                              neg_out
);

    localparam int EW = COMP_WIDTH + 5;
    localparam int ND = amvn_pkg::DIV_STAGES;
    localparam int QB = amvn_pkg::QUOT_BITS;
    localparam int NS = amvn_pkg::DIV_STEPS;

    // remainder and divisor are not needed past the last stage
    logic [EW-1:0] rem_reg [ND-1];
    logic [EW-1:0] d_reg   [ND-1];
    logic [QB-1:0] q_reg   [ND];
    logic          neg_reg [ND];

    genvar s;
    generate
        for (s = 0; s < ND; s++) begin : g_stage
            logic [EW-1:0] rem_prev, d_prev, r_v;
            logic [QB-1:0] q_prev, q_v;
            logic          neg_prev;
            logic [EW:0]   t_v;

            if (s == 0) begin : g_first
                // remainder starts at comp*16, which is below the divisor
                assign rem_prev = EW'({abs_in, {amvn_pkg::REM_PRESHIFT{1'b0}}});
                assign d_prev   = divisor;
                assign q_prev   = '0;
                assign neg_prev = neg_in;
            end else begin : g_next
                assign rem_prev = rem_reg[s-1];
                assign d_prev   = d_reg[s-1];
                assign q_prev   = q_reg[s-1];
                assign neg_prev = neg_reg[s-1];
            end

            always_comb begin
                r_v = rem_prev;
                q_v = q_prev;
                t_v = '0;
                for (int k = 0; k < NS; k++) begin
                    t_v = {r_v, 1'b0};
                    if (t_v >= {1'b0, d_prev}) begin
                        t_v = t_v - {1'b0, d_prev};
                        q_v = {q_v[QB-2:0], 1'b1};
                    end else begin
                        q_v = {q_v[QB-2:0], 1'b0};
                    end
                    r_v = t_v[EW-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv[s]) begin
                    q_reg[s]   <= q_v;
                    neg_reg[s] <= neg_prev;
                end
            end

            if (s < ND - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (adv[s]) begin
                        rem_reg[s] <= r_v;
                        d_reg[s]   <= d_prev;
                    end
                end
            end
        end
    endgenerate

    assign quot    = q_reg[ND-1];
    assign neg_out = neg_reg[ND-1];

endmodule

### hdl/approx_magnitude_vector_normalizer.sv
// top level of the approximate magnitude normalizer: stream ports, stage
// valid/ready chain, divider lanes and output saturation
// depends on amvn_pkg, amvn_front, amvn_div_lane and the defines header
//
//   channel | dir | tdata (low bit up)                       | tuser
//   --------+-----+------------------------------------------+------------
//   s_      | in  | comp_x, comp_y, comp_z, zero pad to byte | none
//   m_      | out | unit_x, unit_y, unit_z, mag_estimate     | zero_vector
//
// one beat per cycle sustained while the output is not back-pressured; at the default
// settings the pipe has three front stages (abs, sort, estimate), eight divider
// stages at two quotient bits each, and one output stage
// aresetn is synchronous, active low, and clears only the stage valid bits
// each stage holds while the stage after it is full and stalled, so a
// back-pressured output fills the pipe without losing or repeating a beat
`timescale 1ns / 1ps
`include "approx_magnitude_vector_normalizer_defines.svh"

module approx_magnitude_vector_normalizer #(
    parameter int COMP_WIDTH = amvn_pkg::COMP_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // comp_x, comp_y, comp_z, zero pad
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // unit_x, unit_y, unit_z, mag_estimate
    output logic [4*amvn_pkg::UNIT_W-1:0] m_tdata,
    // zero_vector
    output logic                          m_tuser
);

    localparam int W  = COMP_WIDTH;
    localparam int EW = COMP_WIDTH + 5;
    localparam int UW = amvn_pkg::UNIT_W;
    localparam int QB = amvn_pkg::QUOT_BITS;
    localparam int FS = amvn_pkg::FRONT_STAGES;
    localparam int ND = amvn_pkg::DIV_STAGES;
    localparam int NS = FS + ND + 1;

    // stage control: a stage loads when it is empty or its successor moves
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] ready;

    genvar i;
    generate
        for (i = 0; i < NS - 1; i++) begin : g_ready
            assign ready[i] = !valid_reg[i] || ready[i+1];
        end
    endgenerate
    assign ready[NS-1] = !valid_reg[NS-1] || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= (k == 0) ? s_tvalid : valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NS-1];

    // front end
    logic [W-1:0]  abs_x, abs_y, abs_z;
    logic [2:0]    neg;
    logic [EW-1:0] est32;
    logic [amvn_pkg::MAG_W-1:0] mag_front;
    logic          zero_front;

    amvn_front #(
        .COMP_WIDTH(COMP_WIDTH)
    ) u_front (
        .aclk   (aclk),
        .adv    (ready[FS-1:0]),
        .comp_x (s_tdata[W-1:0]),
        .comp_y (s_tdata[2*W-1:W]),
        .comp_z (s_tdata[3*W-1:2*W]),
        .abs_x  (abs_x),
        .abs_y  (abs_y),
        .abs_z  (abs_z),
        .neg    (neg),
        .est32  (est32),
        .mag    (mag_front),
        .zero   (zero_front)
    );

    // one divider lane per component, all sharing the estimate as divisor
    logic [QB-1:0] quot [3];
    logic [2:0]    neg_q;
    logic [W-1:0]  abs_v [3];

    assign abs_v[0] = abs_x;
    assign abs_v[1] = abs_y;
    assign abs_v[2] = abs_z;

    generate
        for (i = 0; i < 3; i++) begin : g_lane
            amvn_div_lane #(
                .COMP_WIDTH(COMP_WIDTH)
            ) u_lane (
                .aclk    (aclk),
                .adv     (ready[FS+ND-1:FS]),
                .abs_in  (abs_v[i]),
                .neg_in  (neg[i]),
                .divisor (est32),
                .quot    (quot[i]),
                .neg_out (neg_q[i])
            );
        end
    endgenerate

    // magnitude and zero flag ride alongside the divider stages
    logic [amvn_pkg::MAG_W-1:0] mag_pipe_reg  [ND];
    logic                       zero_pipe_reg [ND];

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ND; k++) begin
            if (ready[FS+k]) begin
                mag_pipe_reg[k]  <= (k == 0) ? mag_front  : mag_pipe_reg[k-1];
                zero_pipe_reg[k] <= (k == 0) ? zero_front : zero_pipe_reg[k-1];
            end
        end
    end

    // output stage: sign, saturation of a plus-one quotient, zero override
    logic [UW-1:0] unit_next [3];
    logic [UW-1:0] unit_reg  [3];
    logic [amvn_pkg::MAG_W-1:0] mag_reg;
    logic          zero_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (zero_pipe_reg[ND-1]) begin
                unit_next[k] = '0;
            end else if (neg_q[k]) begin
                unit_next[k] = UW'(~quot[k] + 1'b1);
            end else if (quot[k] > QB'(amvn_pkg::UNIT_POS_MAX)) begin
                unit_next[k] = amvn_pkg::UNIT_POS_MAX;
            end else begin
                unit_next[k] = UW'(quot[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[NS-1]) begin
            unit_reg <= unit_next;
            mag_reg  <= zero_pipe_reg[ND-1] ? '0 : mag_pipe_reg[ND-1];
            zero_reg <= zero_pipe_reg[ND-1];
        end
    end

    assign m_tdata = {mag_reg, unit_reg[2], unit_reg[1], unit_reg[0]};
    assign m_tuser = zero_reg;

    // a flagged zero vector carries an all-zero payload
    `AMVN_ASSERT(a_zero_payload, (m_tvalid && m_tuser) |-> (m_tdata == '0), "zero beat with data")
    // a nonzero vector always has a nonzero estimate
    `AMVN_ASSERT(a_mag_nonzero, (m_tvalid && !m_tuser) |-> (mag_reg != '0), "zero estimate")
    // an empty output stage means the whole chain can take a beat
    `AMVN_ASSERT(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with output empty")
    // reset empties the pipe
    `AMVN_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> (valid_reg == '0), "valid after reset")

endmodule
